/* design/fip_pkg.sv */
// Shared types and constants for the framed id/result parser.
`default_nettype none

package fip_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  // Token queue between the framing front and the scan back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_CHAR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN    = 2'd3;

  localparam logic [7:0]  START_CHAR_RST = 8'd60;
  localparam logic [7:0]  END_CHAR_RST   = 8'd62;
  localparam logic [7:0]  SEP_CHAR_RST   = 8'd58;
  localparam logic [31:0] UNKNOWN_RST    = 32'hFFFF_FFFF;

  localparam logic [15:0] NO_SEP_ID = 16'h00FF;

  typedef struct packed {
    logic [7:0]         start_char;
    logic [7:0]         end_char;
    logic [7:0]         sep_char;
    logic signed [31:0] unknown_code;
  } cfg_t;

  typedef enum logic [2:0] {
    CLS_WS,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } chr_cls_e;

  typedef enum logic [1:0] {
    TK_ID_CHAR,
    TK_VAL_CHAR,
    TK_END
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    chr_cls_e   cls;
    logic [3:0] digit;
    logic       has_sep;
  } tok_t;

endpackage

`default_nettype wire

/* design/framed_id_result_parser.sv */
// Top level of the framed id/result parser: config registers, front, queue, back.
//
// Usage notes:
//  - rx channel (rx_valid_i / rx_stall_o / rx_byte_i): one received byte per
//    transfer. Bytes outside a frame other than the start char are dropped.
//  - resp channel (resp_valid_o / resp_stall_i): one transfer per end char,
//    carrying response_id_o, response_value_o and no_separator_o.
//  - Config: cfg_we_i writes cfg_data_i into register cfg_index_i
//    (0 start char, 1 end char, 2 separator char, 3 unknown-command code).
//    Write only while the block is idle.
//  - Throughput: one byte per cycle while rx_stall_o is low. The front
//    classifies a byte in its accept cycle; the back runs one multiply-by-ten
//    accumulate per cycle on the queue head token, unless a held result blocks it.
//  - Output path: an end char transferred in is written into the queue, and
//    the back loads the output register from it once it reaches the queue
//    head and the output register is free; resp_valid_o is that register.
//  - Stall: a held result stops the back only once an end token reaches the
//    queue head; tokens ahead of it keep draining, tokens behind it wait.
//    Once the 4-entry token queue fills, rx_stall_o goes high.
//  - Reset: config returns to '<', '>', ':' and -1; the block waits for a
//    start char with an empty queue and no result pending.
`default_nettype none

module framed_id_result_parser
  import fip_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 rx_valid_i,
  output logic                      rx_stall_o,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      resp_valid_o,
  input  wire logic                 resp_stall_i,
  output logic [15:0]               response_id_o,
  output logic signed [31:0]        response_value_o,
  output logic                      no_separator_o
);

  cfg_t cfg_q;
  logic q_push, q_pop, q_empty, q_full;
  tok_t q_in_tok, q_head_tok;

  // Config register file, write-only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char   <= START_CHAR_RST;
      cfg_q.end_char     <= END_CHAR_RST;
      cfg_q.sep_char     <= SEP_CHAR_RST;
      cfg_q.unknown_code <= UNKNOWN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_CHAR: cfg_q.start_char   <= cfg_data_i[7:0];
        REG_END_CHAR:   cfg_q.end_char     <= cfg_data_i[7:0];
        REG_SEP_CHAR:   cfg_q.sep_char     <= cfg_data_i[7:0];
        REG_UNKNOWN:    cfg_q.unknown_code <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: framing and byte classification.
  fip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_tok_o    (q_in_tok)
  );

  // Token queue: lets a stalled result hold back the back end until the queue fills.
  fip_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_tok_i (q_in_tok),
    .pop_i      (q_pop),
    .head_tok_o (q_head_tok),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // Back: id/value scanners and the result register.
  fip_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .unknown_code_i   (cfg_q.unknown_code),
    .head_tok_i       (q_head_tok),
    .empty_i          (q_empty),
    .pop_o            (q_pop),
    .resp_valid_o     (resp_valid_o),
    .resp_stall_i     (resp_stall_i),
    .response_id_o    (response_id_o),
    .response_value_o (response_value_o),
    .no_separator_o   (no_separator_o)
  );

endmodule

`default_nettype wire

/* design/fip_front.sv */
// Framing front: tracks frame/separator state, classifies body bytes into tokens.
`default_nettype none

module fip_front
  import fip_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output tok_t            q_tok_o
);

  logic     in_frame_q, in_frame_d;
  logic     past_sep_q, past_sep_d;
  logic     accept;
  chr_cls_e cls;

  assign rx_stall_o = q_full_i;
  assign accept     = rx_valid_i && !q_full_i;

  always_comb begin
    if (rx_byte_i == 8'd32 || (rx_byte_i >= 8'd9 && rx_byte_i <= 8'd13)) begin
      cls = CLS_WS;
    end else if (rx_byte_i == 8'h2B) begin
      cls = CLS_PLUS;
    end else if (rx_byte_i == 8'h2D) begin
      cls = CLS_MINUS;
    end else if (rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39) begin
      cls = CLS_DIGIT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  always_comb begin
    in_frame_d       = in_frame_q;
    past_sep_d       = past_sep_q;
    q_push_o         = 1'b0;
    q_tok_o.kind     = past_sep_q ? TK_VAL_CHAR : TK_ID_CHAR;
    q_tok_o.cls      = cls;
    q_tok_o.digit    = rx_byte_i[3:0];
    q_tok_o.has_sep  = past_sep_q;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == cfg_i.start_char) begin
          in_frame_d = 1'b1;
          past_sep_d = 1'b0;
        end
      end else if (rx_byte_i == cfg_i.end_char) begin
        // end char wins over separator when both match
        q_push_o     = 1'b1;
        q_tok_o.kind = TK_END;
        in_frame_d   = 1'b0;
        past_sep_d   = 1'b0;
      end else if (!past_sep_q && rx_byte_i == cfg_i.sep_char) begin
        past_sep_d = 1'b1;
      end else begin
        q_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      past_sep_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      past_sep_q <= past_sep_d;
    end
  end

endmodule

`default_nettype wire

/* design/fip_queue.sv */
// Small token FIFO decoupling the front from the back.
`default_nettype none

module fip_queue
  import fip_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire tok_t push_tok_i,
  input  wire logic pop_i,
  output tok_t      head_tok_o,
  output logic      empty_o,
  output logic      full_o
);

  tok_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0] count_q;
  logic                do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign head_tok_o = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/fip_back.sv */
// Scan back: atoi-style id/value scanners and the result output register.
`default_nettype none

module fip_back
  import fip_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic signed [31:0] unknown_code_i,
  input  wire tok_t         head_tok_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              resp_valid_o,
  input  wire logic         resp_stall_i,
  output logic [15:0]       response_id_o,
  output logic signed [31:0] response_value_o,
  output logic              no_separator_o
);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_STOP
  } scan_ph_e;

  scan_ph_e               id_ph_q, id_ph_d, val_ph_q, val_ph_d;
  logic                   id_neg_q, id_neg_d, val_neg_q, val_neg_d;
  logic [15:0]            id_acc_q, id_acc_d;
  logic [VALUE_WIDTH-1:0] val_acc_q, val_acc_d;
  logic                   out_valid_q, out_valid_d;
  logic [15:0]            out_id_q, out_id_d;
  logic [31:0]            out_val_q, out_val_d;
  logic                   out_nosep_q, out_nosep_d;

  scan_ph_e               ph_cur, ph_nxt;
  logic                   take_digit, take_sign;
  logic [VALUE_WIDTH-1:0] val_signed;
  logic [63:0]            val_ext;
  logic                   is_end;

  assign is_end = (head_tok_i.kind == TK_END);
  // Only an end token waits for the output register.
  assign pop_o  = !empty_i && (!is_end || !out_valid_q || !resp_stall_i);

  // One shared scanner step, applied to whichever side the token targets.
  always_comb begin
    ph_cur     = (head_tok_i.kind == TK_VAL_CHAR) ? val_ph_q : id_ph_q;
    ph_nxt     = ph_cur;
    take_digit = 1'b0;
    take_sign  = 1'b0;
    unique case (ph_cur)
      PH_SKIP: begin
        unique case (head_tok_i.cls)
          CLS_WS:    ph_nxt = PH_SKIP;
          CLS_PLUS,
          CLS_MINUS: begin
            ph_nxt    = PH_DIGITS;
            take_sign = 1'b1;
          end
          CLS_DIGIT: begin
            ph_nxt     = PH_DIGITS;
            take_digit = 1'b1;
          end
          default:   ph_nxt = PH_STOP;
        endcase
      end
      PH_DIGITS: begin
        if (head_tok_i.cls == CLS_DIGIT) begin
          take_digit = 1'b1;
        end else begin
          ph_nxt = PH_STOP;
        end
      end
      default: ph_nxt = PH_STOP;
    endcase
  end

  always_comb begin
    val_signed = val_neg_q ? (~val_acc_q + 1'b1) : val_acc_q;
    val_ext    = 64'(val_signed);
  end

  always_comb begin
    id_ph_d     = id_ph_q;
    id_neg_d    = id_neg_q;
    id_acc_d    = id_acc_q;
    val_ph_d    = val_ph_q;
    val_neg_d   = val_neg_q;
    val_acc_d   = val_acc_q;
    out_id_d    = out_id_q;
    out_val_d   = out_val_q;
    out_nosep_d = out_nosep_q;
    out_valid_d = out_valid_q && resp_stall_i;
    if (pop_o) begin
      unique case (head_tok_i.kind)
        TK_ID_CHAR: begin
          id_ph_d = ph_nxt;
          if (take_sign) begin
            id_neg_d = (head_tok_i.cls == CLS_MINUS);
          end
          if (take_digit) begin
            id_acc_d = (id_acc_q << 3) + (id_acc_q << 1) + {12'd0, head_tok_i.digit};
          end
        end
        TK_VAL_CHAR: begin
          val_ph_d = ph_nxt;
          if (take_sign) begin
            val_neg_d = (head_tok_i.cls == CLS_MINUS);
          end
          if (take_digit) begin
            val_acc_d = (val_acc_q << 3) + (val_acc_q << 1)
                      + {{(VALUE_WIDTH-4){1'b0}}, head_tok_i.digit};
          end
        end
        TK_END: begin
          out_valid_d = 1'b1;
          if (head_tok_i.has_sep) begin
            out_id_d    = id_neg_q ? (~id_acc_q + 1'b1) : id_acc_q;
            out_val_d   = val_ext[31:0];
            out_nosep_d = 1'b0;
          end else begin
            out_id_d    = NO_SEP_ID;
            out_val_d   = unknown_code_i;
            out_nosep_d = 1'b1;
          end
          id_ph_d   = PH_SKIP;
          id_neg_d  = 1'b0;
          id_acc_d  = '0;
          val_ph_d  = PH_SKIP;
          val_neg_d = 1'b0;
          val_acc_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_ph_q     <= PH_SKIP;
      id_neg_q    <= 1'b0;
      id_acc_q    <= '0;
      val_ph_q    <= PH_SKIP;
      val_neg_q   <= 1'b0;
      val_acc_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      id_ph_q     <= id_ph_d;
      id_neg_q    <= id_neg_d;
      id_acc_q    <= id_acc_d;
      val_ph_q    <= val_ph_d;
      val_neg_q   <= val_neg_d;
      val_acc_q   <= val_acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_id_q    <= out_id_d;
    out_val_q   <= out_val_d;
    out_nosep_q <= out_nosep_d;
  end

  assign resp_valid_o     = out_valid_q;
  assign response_id_o    = out_id_q;
  assign response_value_o = out_val_q;
  assign no_separator_o   = out_nosep_q;

endmodule

`default_nettype wire

/* design/fip_checker.sv */
// Port-level checker for the framed id/result parser, bound to the top level.
`default_nettype none

module fip_checker
  import fip_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 rx_stall_o,
  input wire logic                 resp_valid_o,
  input wire logic                 resp_stall_i,
  input wire logic [15:0]          response_id_o,
  input wire logic signed [31:0]   response_value_o,
  input wire logic                 no_separator_o
);

  // A held result stays put until transferred.
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && resp_stall_i |=> resp_valid_o && $stable(response_id_o)
      && $stable(response_value_o) && $stable(no_separator_o))
    else $error("result changed while stalled");

  // Missing separator always reports the fixed id.
  a_nosep_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && no_separator_o |-> response_id_o == NO_SEP_ID)
    else $error("no-separator result with wrong id");

  // The token queue only fills up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rx_stall_o) |-> $past(resp_valid_o && resp_stall_i))
    else $error("input stalled without a stalled result");

endmodule

bind framed_id_result_parser fip_checker u_fip_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rx_stall_o       (rx_stall_o),
  .resp_valid_o     (resp_valid_o),
  .resp_stall_i     (resp_stall_i),
  .response_id_o    (response_id_o),
  .response_value_o (response_value_o),
  .no_separator_o   (no_separator_o)
);

`default_nettype wire
